@@ sv/gomr_pkg.sv @@
// Package for the greedy one-to-one match resolver.
// Holds sizes, the candidate type and the sequencer state type; no dependencies.
`default_nettype none
package gomr_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int INDEX_BITS     = 10;
   localparam int RATIO_BITS     = 16;
   localparam int HID_BITS       = 8;
   localparam int ADDR_BITS      = $clog2(MAX_CANDIDATES);
   localparam int CNT_BITS       = $clog2(MAX_CANDIDATES + 1);

   // One stored candidate.
   typedef struct packed {
      logic [RATIO_BITS-1:0] ratio;
      logic [HID_BITS-1:0]   hid;
      logic [INDEX_BITS-1:0] left;
      logic [INDEX_BITS-1:0] right;
   } cand_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage
`default_nettype wire

@@ sv/gomr_store.sv @@
// Candidate store: single write port and one registered read port.
// Depends on gomr_pkg.
`default_nettype none
module gomr_store
   import gomr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire cand_type             wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output      cand_type             rd_data
);

   cand_type mem [MAX_CANDIDATES];
   cand_type rd_data_ff;

   // Write during loading, read one entry each cycle during a scan.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/gomr_compare.sv @@
// Shared ordering comparator: ratio descending, then id, left, right ascending.
// Depends on gomr_pkg.
`default_nettype none
module gomr_compare
   import gomr_pkg::*;
(
   input  wire cand_type a,
   input  wire cand_type b,
   output logic          a_first
);

   // True when a must strictly precede b in the resolve order.
   always_comb begin
      priority if (a.ratio != b.ratio) begin
         a_first = a.ratio > b.ratio;
      end else if (a.hid != b.hid) begin
         a_first = a.hid < b.hid;
      end else if (a.left != b.left) begin
         a_first = a.left < b.left;
      end else begin
         a_first = a.right < b.right;
      end
   end

endmodule
`default_nettype wire

@@ sv/greedy_one_to_one_match_resolver_unit.sv @@
// Greedy one-to-one match resolver. Candidates are loaded one per cycle into a
// 64-entry store until a transaction marked final arrives; the store is then
// resolved by repeated passes, each pass reading every stored entry once through
// the single read port and the shared comparator to find the best candidate that
// shares no index with any already chosen. A resolve of n candidates producing k
// results takes k + 1 passes, and a pass ends in a decision step that waits
// while a waiting result is stalled. No input is taken meanwhile. Each chosen
// candidate is issued at the end of the following pass, so run_end can be
// marked on the last one. No clearing pass is needed after reset.
`default_nettype none
module greedy_one_to_one_match_resolver_unit
   import gomr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [RATIO_BITS-1:0] req_ratio,
   input  wire logic [HID_BITS-1:0]   req_heuristic_id,
   input  wire logic [INDEX_BITS-1:0] req_left_index,
   input  wire logic [INDEX_BITS-1:0] req_right_index,
   input  wire logic                  req_final_item,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [RATIO_BITS-1:0] rsp_out_ratio,
   output      logic [HID_BITS-1:0]   rsp_out_heuristic_id,
   output      logic [INDEX_BITS-1:0] rsp_out_left_index,
   output      logic [INDEX_BITS-1:0] rsp_out_right_index,
   output      logic                  rsp_run_end,
   output      logic                  rsp_overflow
);

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic                      ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]       ptr_ff, ptr_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [ADDR_BITS-1:0]      rd_idx_ff, rd_idx_in;
   logic [MAX_CANDIDATES-1:0] alive_ff, alive_in;
   cand_type                  best_ff, best_in;
   logic                      best_valid_ff, best_valid_in;
   cand_type                  pend_ff, pend_in;
   logic                      pend_valid_ff, pend_valid_in;
   cand_type                  out_ff, out_in;
   logic                      out_end_ff, out_end_in;
   logic                      out_ovf_ff, out_ovf_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic     accept;
   logic     wr_en;
   cand_type req_cand;
   cand_type rd_data;
   logic     rd_first;
   logic     entry_alive;
   logic     last_entry;
   logic     out_free;

   assign req_cand = '{ratio: req_ratio, hid: req_heuristic_id,
                       left: req_left_index, right: req_right_index};
   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (count_ff != CNT_BITS'(MAX_CANDIDATES));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   gomr_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data (req_cand),
      .rd_addr (ptr_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   gomr_compare u_compare (
      .a       (rd_data),
      .b       (best_ff),
      .a_first (rd_first)
   );

   // An entry stays alive until it shares an index with a chosen candidate.
   assign entry_alive = alive_ff[rd_idx_ff] &&
                        !(pend_valid_ff && ((rd_data.left == pend_ff.left) ||
                                            (rd_data.right == pend_ff.right)));
   assign last_entry  = (CNT_BITS'(rd_idx_ff) + CNT_BITS'(1)) == count_ff;

   // Sequencer: loading, scan passes and the decision after each pass.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      ovf_in        = ovf_ff;
      ptr_in        = ptr_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = ptr_ff[ADDR_BITS-1:0];
      alive_in      = alive_ff;
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_end_in    = out_end_ff;
      out_ovf_in    = out_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_final_item) begin
                  state_in      = ST_SCAN;
                  ovf_in        = dropped_ff || !wr_en;
                  ptr_in        = '0;
                  alive_in      = '1;
                  best_valid_in = 1'b0;
                  pend_valid_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // Issue the next read while entries remain.
            if (ptr_ff != count_ff) begin
               rd_valid_in = 1'b1;
               ptr_in      = ptr_ff + CNT_BITS'(1);
            end
            // Evaluate the entry read in the previous cycle.
            if (rd_valid_ff) begin
               alive_in[rd_idx_ff] = entry_alive;
               if (entry_alive && (!best_valid_ff || rd_first)) begin
                  best_in       = rd_data;
                  best_valid_in = 1'b1;
               end
               if (last_entry) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (best_valid_ff) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_in       = pend_ff;
                     out_end_in   = 1'b0;
                     out_ovf_in   = ovf_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in       = best_ff;
                  pend_valid_in = 1'b1;
                  best_valid_in = 1'b0;
                  ptr_in        = '0;
                  state_in      = ST_SCAN;
               end
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_in       = pend_ff;
                  out_end_in   = 1'b1;
                  out_ovf_in   = ovf_ff;
                  rsp_valid_in = 1'b1;
               end
               pend_valid_in = 1'b0;
               count_in      = '0;
               dropped_in    = 1'b0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         ptr_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         ptr_ff        <= ptr_in;
         rd_valid_ff   <= rd_valid_in;
         best_valid_ff <= best_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and per-resolve working registers.
   always_ff @(posedge clock) begin
      ovf_ff     <= ovf_in;
      rd_idx_ff  <= rd_idx_in;
      alive_ff   <= alive_in;
      best_ff    <= best_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
      out_end_ff <= out_end_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_ratio        = out_ff.ratio;
   assign rsp_out_heuristic_id = out_ff.hid;
   assign rsp_out_left_index   = out_ff.left;
   assign rsp_out_right_index  = out_ff.right;
   assign rsp_run_end          = out_end_ff;
   assign rsp_overflow         = out_ovf_ff;

   // The fill count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_CANDIDATES))
      else $error("candidate count beyond store depth");

   // A scan only runs over a non-empty store.
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0))
      else $error("scan started on an empty store");

   // Every evaluated entry lies below the fill count.
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (CNT_BITS'(rd_idx_ff) < count_ff))
      else $error("read beyond filled entries");

   // A new result is only issued once the chosen candidate is pending.
   a_issue_from_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && rsp_valid_in && !(rsp_valid_ff && rsp_stall))
         |-> pend_valid_ff)
      else $error("result issued without a pending candidate");

endmodule
`default_nettype wire

@@ dv/greedy_one_to_one_match_resolver_unit_tb.sv @@
// Self-checking testbench for the greedy one-to-one match resolver.
// Depends on gomr_pkg and greedy_one_to_one_match_resolver_unit only.
// Sends candidate sets under random idling and checks each result against a predictor.
`timescale 1ns / 100ps
module greedy_one_to_one_match_resolver_unit_tb
   import gomr_pkg::*;
;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 2 * (MAX_CANDIDATES + 2);
   localparam int NUM_ITEMS    = 160;

   // One resolved match as it should appear on the result channel.
   typedef struct {
      cand_type   cand;
      logic       run_end;
      logic       overflow;
   } match_type;

   // One directed stimulus row; typed rows are single-candidate sets that match themselves.
   typedef struct {
      logic [RATIO_BITS-1:0] ratio;
      logic [HID_BITS-1:0]   hid;
      logic [INDEX_BITS-1:0] left;
      logic [INDEX_BITS-1:0] right;
      logic                  fin;
      bit                    typed;
   } row_type;

   localparam int NUM_ROWS = 13;
   row_type directed_rows [NUM_ROWS] = '{
      '{16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF, 1'b1, 1'b1},
      '{16'h0000, 8'h00, 10'h000, 10'h000, 1'b1, 1'b1},
      '{16'h8000, 8'hAA, 10'h155, 10'h2AA, 1'b1, 1'b1},
      '{16'd100,  8'd3,  10'd1,   10'd1,   1'b0, 1'b0},
      '{16'd100,  8'd2,  10'd1,   10'd2,   1'b0, 1'b0},
      '{16'd100,  8'd2,  10'd0,   10'd2,   1'b0, 1'b0},
      '{16'd100,  8'd2,  10'd0,   10'd1,   1'b0, 1'b0},
      '{16'd200,  8'd9,  10'd5,   10'd5,   1'b0, 1'b0},
      '{16'd200,  8'd9,  10'd5,   10'd5,   1'b1, 1'b0},
      '{16'd50,   8'd1,  10'd7,   10'd8,   1'b0, 1'b0},
      '{16'd60,   8'd1,  10'd7,   10'd9,   1'b0, 1'b0},
      '{16'd60,   8'd1,  10'd6,   10'd8,   1'b0, 1'b0},
      '{16'd40,   8'd0,  10'd6,   10'd9,   1'b1, 1'b0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [RATIO_BITS-1:0] req_ratio;
   logic [HID_BITS-1:0]   req_heuristic_id;
   logic [INDEX_BITS-1:0] req_left_index;
   logic [INDEX_BITS-1:0] req_right_index;
   logic                  req_final_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [RATIO_BITS-1:0] rsp_out_ratio;
   logic [HID_BITS-1:0]   rsp_out_heuristic_id;
   logic [INDEX_BITS-1:0] rsp_out_left_index;
   logic [INDEX_BITS-1:0] rsp_out_right_index;
   logic                  rsp_run_end;
   logic                  rsp_overflow;

   greedy_one_to_one_match_resolver_unit DUT (.*);

   // Predictor state: the pending set, its drop flag and the queue of matches still due.
   cand_type  pending_set [$];
   bit        pending_dropped;
   match_type due_matches [$];
   bit        left_taken  [1 << INDEX_BITS];
   bit        right_taken [1 << INDEX_BITS];
   int        error_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct;
   int        recv_idle_pct;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // True when candidate a is ranked strictly ahead of candidate b.
   function automatic bit ranks_ahead(cand_type a, cand_type b);
      if (a.ratio != b.ratio) return a.ratio > b.ratio;
      if (a.hid != b.hid) return a.hid < b.hid;
      if (a.left != b.left) return a.left < b.left;
      return a.right < b.right;
   endfunction

   // Sort the pending set, walk it greedily and queue the matches it yields.
   task automatic resolve_set();
      cand_type  ranked [$];
      cand_type  tmp;
      match_type m;
      int        first_new;
      int        j;
      ranked = pending_set;
      for (int i = 1; i < ranked.size(); i++) begin
         j = i;
         while (j > 0 && ranks_ahead(ranked[j], ranked[j-1])) begin
            tmp = ranked[j];
            ranked[j] = ranked[j-1];
            ranked[j-1] = tmp;
            j--;
         end
      end
      foreach (left_taken[k]) begin
         left_taken[k] = 1'b0;
         right_taken[k] = 1'b0;
      end
      first_new = due_matches.size();
      foreach (ranked[i]) begin
         if (!left_taken[ranked[i].left] && !right_taken[ranked[i].right]) begin
            left_taken[ranked[i].left] = 1'b1;
            right_taken[ranked[i].right] = 1'b1;
            m.cand     = ranked[i];
            m.run_end  = 1'b0;
            m.overflow = pending_dropped;
            due_matches.insert(due_matches.size(), m);
         end
      end
      if (due_matches.size() > first_new)
         due_matches[due_matches.size()-1].run_end = 1'b1;
      pending_set.delete();
      pending_dropped = 1'b0;
   endtask

   // Drive one candidate transaction and wait for it to be taken.
   task automatic send_candidate(cand_type c, logic fin, bit typed);
      match_type m;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_ratio        <= c.ratio;
      req_heuristic_id <= c.hid;
      req_left_index   <= c.left;
      req_right_index  <= c.right;
      req_final_item   <= fin;
      do @(posedge clock); while (req_stall);
      // Typed rows carry their expected match directly; the rest go through the predictor.
      if (typed) begin
         m.cand     = c;
         m.run_end  = 1'b1;
         m.overflow = 1'b0;
         due_matches.insert(due_matches.size(), m);
      end else begin
         if (pending_set.size() < MAX_CANDIDATES) pending_set.insert(pending_set.size(), c);
         else pending_dropped = 1'b1;
         if (fin) resolve_set();
      end
   endtask

   // Send one random set of the given size; indices and scores are mostly drawn narrow to force conflicts.
   task automatic send_random_set(int size);
      cand_type c;
      bit       wide;
      for (int i = 0; i < size; i++) begin
         wide = ($urandom_range(3) == 0);
         c.ratio = wide ? RATIO_BITS'($urandom) : RATIO_BITS'($urandom_range(3) * 16'h4000);
         c.hid   = wide ? HID_BITS'($urandom) : HID_BITS'($urandom_range(2));
         c.left  = wide ? INDEX_BITS'($urandom) : INDEX_BITS'($urandom_range(5));
         c.right = wide ? INDEX_BITS'($urandom) : INDEX_BITS'($urandom_range(5));
         send_candidate(c, i == size - 1, 1'b0);
      end
   endtask

   // Hold off the sender until every due match has been seen.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_matches.size() != 0) @(posedge clock);
   endtask

   // Result checker.
   always @(posedge clock) begin
      match_type m;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_matches.size() == 0) begin
            $display("%0t: unexpected match expected none, actual %h %h %h %h %b %b", $time,
                     rsp_out_ratio, rsp_out_heuristic_id, rsp_out_left_index,
                     rsp_out_right_index, rsp_run_end, rsp_overflow);
            error_count++;
         end else begin
            m = due_matches.pop_front();
            if (rsp_out_ratio !== m.cand.ratio || rsp_out_heuristic_id !== m.cand.hid ||
                rsp_out_left_index !== m.cand.left || rsp_out_right_index !== m.cand.right ||
                rsp_run_end !== m.run_end || rsp_overflow !== m.overflow) begin
               $display("%0t: match mismatch expected %h %h %h %h %b %b, actual %h %h %h %h %b %b",
                        $time, m.cand.ratio, m.cand.hid, m.cand.left, m.cand.right,
                        m.run_end, m.overflow, rsp_out_ratio, rsp_out_heuristic_id,
                        rsp_out_left_index, rsp_out_right_index, rsp_run_end, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      int       sent;
      int       size;
      cand_type c;
      pending_dropped = 1'b0;
      send_idle_pct   = 11;
      recv_idle_pct   = 50;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_ratio        <= '0;
      req_heuristic_id <= '0;
      req_left_index   <= '0;
      req_right_index  <= '0;
      req_final_item   <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, tie-breaking order and index conflicts.
      for (int i = 0; i < NUM_ROWS; i++) begin
         c = '{directed_rows[i].ratio, directed_rows[i].hid,
               directed_rows[i].left, directed_rows[i].right};
         send_candidate(c, directed_rows[i].fin, directed_rows[i].typed);
      end
      wait_drained();

      // A set larger than the store, so the tail and the final candidate are dropped.
      send_random_set(MAX_CANDIDATES + 2);
      wait_drained();

      // Random sets through the three idling phases.
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 50 : 0;
         recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 11 : 0;
         while (sent < (phase + 1) * (NUM_ITEMS - NUM_ROWS - MAX_CANDIDATES - 2) / 3) begin
            size = ($urandom_range(7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            send_random_set(size);
            sent += size;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && due_matches.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
